// ===== sv/fyee_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fyee_pkg
// Shared types, constants and helpers for the Yee cell update engine.
// ----------------------------------------------------------------------------
package fyee_pkg;

  localparam int MATERIALS_DEF          = 64;
  localparam int COEFS_PER_MATERIAL_DEF = 5;
  localparam int FIELD_BITS_DEF         = 32;

  localparam int MAT_W   = 6;
  localparam int SLOT_W  = 3;
  localparam int COMP_W  = 2;
  localparam int COEF_W  = 32;
  localparam int VAL_W   = 32;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int FRAC_SH = 24;

  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic KIND_E = 1'b0;
  localparam logic KIND_H = 1'b1;

  localparam logic [COMP_W-1:0] COMP_X = 2'd0;
  localparam logic [COMP_W-1:0] COMP_Y = 2'd1;

  localparam logic [SLOT_W-1:0] SLOT_C0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_1  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_2  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_3  = 3'd3;

  // one classified item between front and back
  typedef struct packed {
    logic                     is_update;
    logic                     mat_ok;
    logic                     kind;
    logic [COMP_W-1:0]        comp;
    logic [MAT_W-1:0]         material;
    logic [SLOT_W-1:0]        slot;
    logic signed [COEF_W-1:0] coef;
    logic signed [VAL_W-1:0]  own;
    logic signed [DIFF_W-1:0] d1;
    logic signed [DIFF_W-1:0] d2;
  } fyee_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fyee_qstat_t;

  // first curl slot: x -> 2, y -> 3, z -> 1
  function automatic logic [SLOT_W-1:0] slot_a(input logic [COMP_W-1:0] comp);
    logic [SLOT_W-1:0] s;
    case (comp)
      COMP_X:  s = SLOT_2;
      COMP_Y:  s = SLOT_3;
      default: s = SLOT_1;
    endcase
    return s;
  endfunction

  // second curl slot: x -> 3, y -> 1, z -> 2
  function automatic logic [SLOT_W-1:0] slot_b(input logic [COMP_W-1:0] comp);
    logic [SLOT_W-1:0] s;
    case (comp)
      COMP_X:  s = SLOT_3;
      COMP_Y:  s = SLOT_1;
      default: s = SLOT_2;
    endcase
    return s;
  endfunction

  function automatic int sat_width(input int field_bits);
    return (field_bits > VAL_W) ? VAL_W : field_bits;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_max(input int w);
    logic signed [63:0] m;
    m = (64'sd1 <<< (w - 1)) - 64'sd1;
    return m[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_min(input int w);
    return ~sat_max(w);
  endfunction

endpackage

// ===== sv/fyee_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fyee_front
// Takes input transfers, drops loads that fall outside the store, checks the
// material range, forms the neighbor differences and queues the item.
// ----------------------------------------------------------------------------
module fyee_front import fyee_pkg::*; #(
  parameter int MATERIALS          = MATERIALS_DEF,
  parameter int COEFS_PER_MATERIAL = COEFS_PER_MATERIAL_DEF
) (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_command,
  input  logic                     in_field_kind,
  input  logic [COMP_W-1:0]        in_component,
  input  logic [MAT_W-1:0]         in_material,
  input  logic [SLOT_W-1:0]        in_coef_slot,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic signed [VAL_W-1:0]  in_own_value,
  input  logic signed [VAL_W-1:0]  in_first_upper,
  input  logic signed [VAL_W-1:0]  in_first_lower,
  input  logic signed [VAL_W-1:0]  in_second_upper,
  input  logic signed [VAL_W-1:0]  in_second_lower,
  input  fyee_qstat_t              q_stat,
  output logic                     q_push,
  output fyee_item_t               q_item
);

  logic mat_ok;
  logic slot_ok;
  logic is_update;

  assign in_stall  = q_stat.full;
  assign is_update = (in_command == CMD_UPDATE);
  assign mat_ok    = (32'(in_material) < 32'(MATERIALS));
  assign slot_ok   = (32'(in_coef_slot) < 32'(COEFS_PER_MATERIAL));

  // loads outside the store are consumed here and never queued
  assign q_push = in_valid && !q_stat.full && (is_update || (mat_ok && slot_ok));

  always_comb begin
    q_item           = '0;
    q_item.is_update = is_update;
    q_item.mat_ok    = mat_ok;
    q_item.kind      = in_field_kind;
    q_item.comp      = in_component;
    q_item.material  = in_material;
    q_item.slot      = in_coef_slot;
    q_item.coef      = in_coef_value;
    q_item.own       = in_own_value;
    q_item.d1        = DIFF_W'(in_first_upper) - DIFF_W'(in_first_lower);
    q_item.d2        = DIFF_W'(in_second_upper) - DIFF_W'(in_second_lower);
  end

endmodule

// ===== sv/fyee_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fyee_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module fyee_queue import fyee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  fyee_item_t  push_item,
  input  logic        pop,
  output fyee_item_t  pop_item,
  output fyee_qstat_t stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fyee_item_t       slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_item   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/fyee_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fyee_back
// Coefficient store and update datapath: row read, three products, signed
// sum, floor shift and saturation into the output register.
// ----------------------------------------------------------------------------
module fyee_back import fyee_pkg::*; #(
  parameter int MATERIALS          = MATERIALS_DEF,
  parameter int COEFS_PER_MATERIAL = COEFS_PER_MATERIAL_DEF,
  parameter int FIELD_BITS         = FIELD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fyee_qstat_t             q_stat,
  input  fyee_item_t              q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_new_value,
  output logic                    out_saturated
);

  localparam int ROWS   = 2 * MATERIALS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CS_W   = $clog2(COEFS_PER_MATERIAL);
  localparam int SAT_W  = sat_width(FIELD_BITS);
  localparam int P0_W   = COEF_W + VAL_W;
  localparam int PD_W   = COEF_W + DIFF_W;
  localparam int SUM_W  = PD_W + 2;
  localparam int V_W    = SUM_W - FRAC_SH;

  localparam logic signed [V_W-1:0] V_HI = V_W'(sat_max(SAT_W));
  localparam logic signed [V_W-1:0] V_LO = V_W'(sat_min(SAT_W));

  typedef logic [COEFS_PER_MATERIAL-1:0][COEF_W-1:0] row_t;

  // one row per (table, material); a load writes one word of it
  row_t store [ROWS];

  logic             en;
  logic [ROW_W-1:0] row_addr;
  row_t             row_rd_r;

  // stage 1: row read
  logic                     s1_valid_r;
  logic                     s1_kind_r;
  logic [COMP_W-1:0]        s1_comp_r;
  logic                     s1_mat_ok_r;
  logic signed [VAL_W-1:0]  s1_own_r;
  logic signed [DIFF_W-1:0] s1_d1_r;
  logic signed [DIFF_W-1:0] s1_d2_r;

  // stage 2: products
  logic                     s2_valid_r;
  logic                     s2_kind_r;
  logic signed [P0_W-1:0]   s2_p0_r;
  logic signed [PD_W-1:0]   s2_pa_r;
  logic signed [PD_W-1:0]   s2_pb_r;
  logic signed [COEF_W-1:0] c0, ca, cb;

  // stage 3: sum
  logic                     s3_valid_r;
  logic signed [SUM_W-1:0]  s3_sum_r, s3_sum_nxt;
  logic signed [SUM_W-1:0]  term_a, term_b;

  // output register
  logic                     out_valid_r;
  logic signed [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic                     out_sat_r, out_sat_nxt;
  logic signed [V_W-1:0]    v;

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && !q_stat.empty;

  assign row_addr = q_item.kind ? ROW_W'(MATERIALS) + ROW_W'(q_item.material)
                                : ROW_W'(q_item.material);

  always_ff @(posedge clk) begin
    if (q_pop && !q_item.is_update) begin
      store[row_addr][CS_W'(q_item.slot)] <= q_item.coef;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_rd_r <= store[row_addr];
    end
  end

  // out-of-range material runs with zero coefficients
  always_comb begin
    c0 = '0;
    ca = '0;
    cb = '0;
    if (s1_mat_ok_r) begin
      c0 = row_rd_r[CS_W'(SLOT_C0)];
      ca = row_rd_r[CS_W'(slot_a(s1_comp_r))];
      cb = row_rd_r[CS_W'(slot_b(s1_comp_r))];
    end
  end

  // E: +a -b, H: -a +b
  always_comb begin
    term_a = (s2_kind_r == KIND_H) ? -SUM_W'(s2_pa_r) : SUM_W'(s2_pa_r);
    term_b = (s2_kind_r == KIND_H) ? SUM_W'(s2_pb_r) : -SUM_W'(s2_pb_r);
    s3_sum_nxt = SUM_W'(s2_p0_r) + term_a + term_b;
  end

  // arithmetic shift gives the floor
  always_comb begin
    v             = $signed(s3_sum_r[SUM_W-1:FRAC_SH]);
    out_sat_nxt   = 1'b0;
    out_value_nxt = v[VAL_W-1:0];
    if (v > V_HI) begin
      out_value_nxt = V_HI[VAL_W-1:0];
      out_sat_nxt   = 1'b1;
    end else if (v < V_LO) begin
      out_value_nxt = V_LO[VAL_W-1:0];
      out_sat_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_pop && q_item.is_update;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r   <= q_item.kind;
      s1_comp_r   <= q_item.comp;
      s1_mat_ok_r <= q_item.mat_ok;
      s1_own_r    <= q_item.own;
      s1_d1_r     <= q_item.d1;
      s1_d2_r     <= q_item.d2;
      s2_kind_r   <= s1_kind_r;
      s2_p0_r     <= c0 * s1_own_r;
      s2_pa_r     <= ca * s1_d1_r;
      s2_pb_r     <= cb * s1_d2_r;
      s3_sum_r    <= s3_sum_nxt;
      out_value_r <= out_value_nxt;
      out_sat_r   <= out_sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_value = out_value_r;
  assign out_saturated = out_sat_r;

endmodule

// ===== sv/fdtd_yee_cell_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_yee_cell_update
// Yee cell field update with a per-material coefficient store.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless stalled. A load writes one Q8.24
// coefficient into the electric or magnetic table and gives no result; an
// update computes one Q16.16 field component and gives one result, saturated
// and flagged. The store holds one row of COEFS_PER_MATERIAL words for each
// table and material and reads a whole row at once, so c0 and both curl
// coefficients come from a single access and a load followed at once by an
// update of the same material sees the new word. The store is not cleared at
// reset: coefficients must be loaded before they are used. The three
// multipliers, the sum and the saturation sit in stages of their own. A
// two-entry queue after the input keeps taking items for a while when the
// output stalls.
// ----------------------------------------------------------------------------
module fdtd_yee_cell_update import fyee_pkg::*; #(
  parameter int MATERIALS          = MATERIALS_DEF,
  parameter int COEFS_PER_MATERIAL = COEFS_PER_MATERIAL_DEF,
  parameter int FIELD_BITS         = FIELD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_command,
  input  logic                     in_field_kind,
  input  logic [COMP_W-1:0]        in_component,
  input  logic [MAT_W-1:0]         in_material,
  input  logic [SLOT_W-1:0]        in_coef_slot,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic signed [VAL_W-1:0]  in_own_value,
  input  logic signed [VAL_W-1:0]  in_first_upper,
  input  logic signed [VAL_W-1:0]  in_first_lower,
  input  logic signed [VAL_W-1:0]  in_second_upper,
  input  logic signed [VAL_W-1:0]  in_second_lower,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  out_new_value,
  output logic                     out_saturated
);

  localparam int SAT_W = sat_width(FIELD_BITS);
  localparam logic signed [VAL_W-1:0] OUT_HI = sat_max(SAT_W);
  localparam logic signed [VAL_W-1:0] OUT_LO = sat_min(SAT_W);

  fyee_qstat_t q_stat;
  fyee_item_t  push_item;
  fyee_item_t  pop_item;
  logic        q_push;
  logic        q_pop;

  fyee_front #(
    .MATERIALS          (MATERIALS),
    .COEFS_PER_MATERIAL (COEFS_PER_MATERIAL)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_field_kind   (in_field_kind),
    .in_component    (in_component),
    .in_material     (in_material),
    .in_coef_slot    (in_coef_slot),
    .in_coef_value   (in_coef_value),
    .in_own_value    (in_own_value),
    .in_first_upper  (in_first_upper),
    .in_first_lower  (in_first_lower),
    .in_second_upper (in_second_upper),
    .in_second_lower (in_second_lower),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  fyee_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  fyee_back #(
    .MATERIALS          (MATERIALS),
    .COEFS_PER_MATERIAL (COEFS_PER_MATERIAL),
    .FIELD_BITS         (FIELD_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_new_value (out_new_value),
    .out_saturated (out_saturated)
  );

  // a clipped result sits exactly on one of the limits
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> (out_new_value == OUT_HI || out_new_value == OUT_LO))
    else $error("saturated result not at a limit");

  // the queue comes out of reset empty, so input is open right after reset
  a_open_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // an empty queue never stalls the input side
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !in_stall)
    else $error("input stalled with empty queue");

  // nothing is pushed into or popped from the queue beyond its bounds
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push |-> !q_stat.full) and (q_pop |-> !q_stat.empty))
    else $error("queue overrun or underrun");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Yee cell field update engine.
// ----------------------------------------------------------------------------
// A short table of hand-picked loads and updates goes first: coefficient and
// field extremes, saturation both ways, floor rounding, every component code
// and ignored slots. Random traffic follows in five mixes of sender gaps and
// receiver stalls, one with a long output hold-off that backs up the input.
// Loads fill a local copy of the coefficient tables; every update is checked
// against a hand-given result or a local bit-accurate computation of it.
// ----------------------------------------------------------------------------
module tb_top;
  import fyee_pkg::*;

  localparam int COEFS_PER_ROW = COEFS_PER_MATERIAL_DEF;
  localparam logic [COMP_W-1:0] COMP_Z   = 2'd2;
  localparam logic [COMP_W-1:0] COMP_ALT = 2'd3;
  localparam logic [SLOT_W-1:0] SLOT_4   = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_BAD = 3'd7;

  localparam logic signed [31:0] VAL_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [31:0] VAL_MIN  = 32'sh80000000;
  localparam logic signed [31:0] COEF_ONE = 32'sh01000000;
  localparam logic signed [71:0] SUM_HI   = 72'sd2147483647;
  localparam logic signed [71:0] SUM_LO   = -72'sd2147483648;
  localparam logic signed [31:0] FIELD_EDGES [4] =
    '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, 32'shFFFFFFFF};

  typedef struct {
    logic                     command;
    logic                     field_kind;
    logic [COMP_W-1:0]        component;
    logic [MAT_W-1:0]         material;
    logic [SLOT_W-1:0]        coef_slot;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [VAL_W-1:0]  own_value;
    logic signed [VAL_W-1:0]  first_upper;
    logic signed [VAL_W-1:0]  first_lower;
    logic signed [VAL_W-1:0]  second_upper;
    logic signed [VAL_W-1:0]  second_lower;
  } cell_item_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    sat;
  } cell_result_t;

  typedef struct {
    cell_item_t   item;
    bit           typed;
    cell_result_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic in_field_kind = 1'b0;
  logic [COMP_W-1:0] in_component = '0;
  logic [MAT_W-1:0] in_material = '0;
  logic [SLOT_W-1:0] in_coef_slot = '0;
  logic signed [COEF_W-1:0] in_coef_value = '0;
  logic signed [VAL_W-1:0] in_own_value = '0;
  logic signed [VAL_W-1:0] in_first_upper = '0;
  logic signed [VAL_W-1:0] in_first_lower = '0;
  logic signed [VAL_W-1:0] in_second_upper = '0;
  logic signed [VAL_W-1:0] in_second_lower = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_new_value;
  logic out_saturated;

  // local copy of both coefficient tables, written at load transfer
  logic signed [COEF_W-1:0] coef_mem [0:1][0:63][0:COEFS_PER_ROW-1];
  // slots already issued as loads, used to pick rows that are safe to update
  bit coef_seen [0:1][0:63][0:COEFS_PER_ROW-1];
  int ready_rows [$];
  cell_result_t field_results [$];
  table_row_t dir_rows [$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  // hold-off request from the stimulus side, taken up by the receiver
  int hold_len = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int mismatches = 0;
  int loads_done = 0;
  int updates_done = 0;
  int results_seen = 0;
  int sat_seen = 0;
  int held_cycles = 0;

  fdtd_yee_cell_update dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_field_kind  (in_field_kind),
    .in_component   (in_component),
    .in_material    (in_material),
    .in_coef_slot   (in_coef_slot),
    .in_coef_value  (in_coef_value),
    .in_own_value   (in_own_value),
    .in_first_upper (in_first_upper),
    .in_first_lower (in_first_lower),
    .in_second_upper(in_second_upper),
    .in_second_lower(in_second_lower),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_new_value  (out_new_value),
    .out_saturated  (out_saturated)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic bit row_loaded(input logic kind, input logic [MAT_W-1:0] mat);
    return coef_seen[kind][mat][0] && coef_seen[kind][mat][1] &&
           coef_seen[kind][mat][2] && coef_seen[kind][mat][3];
  endfunction

  // exact Q24.40 sum, floor shift by 24, clip to 32 bits
  function automatic cell_result_t next_field_value(input cell_item_t it);
    logic [SLOT_W-1:0] sa, sb;
    logic signed [71:0] c0, ca, cb, own, d1, d2, acc, shifted;
    cell_result_t r;
    case (it.component)
      COMP_X:  begin sa = SLOT_2; sb = SLOT_3; end
      COMP_Y:  begin sa = SLOT_3; sb = SLOT_1; end
      default: begin sa = SLOT_1; sb = SLOT_2; end  // code 3 acts as z
    endcase
    c0 = coef_mem[it.field_kind][it.material][SLOT_C0];
    ca = coef_mem[it.field_kind][it.material][sa];
    cb = coef_mem[it.field_kind][it.material][sb];
    own = it.own_value;
    d1 = $signed(it.first_upper) - $signed(it.first_lower);
    d2 = $signed(it.second_upper) - $signed(it.second_lower);
    acc = c0 * own;
    if (it.field_kind == KIND_E) acc = acc + ca * d1 - cb * d2;
    else acc = acc - ca * d1 + cb * d2;
    shifted = acc >>> FRAC_SH;
    r.sat = 1'b1;
    if (shifted > SUM_HI) r.value = VAL_MAX;
    else if (shifted < SUM_LO) r.value = VAL_MIN;
    else begin
      r.value = shifted[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic cell_item_t coef_load(input logic kind, input logic [MAT_W-1:0] mat,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic signed [31:0] coef);
    cell_item_t it;
    it = '{default: '0};
    it.command = CMD_LOAD;
    it.field_kind = kind;
    it.material = mat;
    it.coef_slot = slot;
    it.coef_value = coef;
    return it;
  endfunction

  function automatic cell_item_t cell_update(input logic kind, input logic [COMP_W-1:0] comp,
                                             input logic [MAT_W-1:0] mat,
                                             input logic signed [31:0] own,
                                             input logic signed [31:0] fu,
                                             input logic signed [31:0] fl,
                                             input logic signed [31:0] su,
                                             input logic signed [31:0] sl);
    cell_item_t it;
    it = '{default: '0};
    it.command = CMD_UPDATE;
    it.field_kind = kind;
    it.component = comp;
    it.material = mat;
    it.own_value = own;
    it.first_upper = fu;
    it.first_lower = fl;
    it.second_upper = su;
    it.second_lower = sl;
    return it;
  endfunction

  task automatic add_row(input cell_item_t it, input bit typed,
                         input logic signed [31:0] v, input logic s);
    table_row_t row;
    row.item = it;
    row.typed = typed;
    row.res.value = v;
    row.res.sat = s;
    dir_rows.push_back(row);
  endtask

  function automatic logic signed [31:0] rand_field();
    int pick;
    logic signed [31:0] v;
    pick = $urandom_range(99);
    if (pick < 10) v = FIELD_EDGES[$urandom_range(3)];
    else if (pick < 40) v = $urandom;
    else v = $signed($urandom_range(32'h001FFFFF)) - 32'sh00100000;
    return v;
  endfunction

  function automatic logic signed [31:0] rand_coef();
    int pick;
    logic signed [31:0] v;
    pick = $urandom_range(99);
    if (pick < 50) v = $signed($urandom_range(32'h03FFFFFF)) - 32'sh02000000;
    else if (pick < 75) v = $urandom;
    else v = $signed($urandom_range(511)) - 32'sd256;  // exercises floor rounding
    return v;
  endfunction

  function automatic cell_item_t rand_item();
    cell_item_t it;
    it.command = 1'($urandom_range(1));
    it.field_kind = 1'($urandom_range(1));
    it.component = COMP_W'($urandom_range(3));
    it.material = MAT_W'($urandom_range(63));
    it.coef_slot = SLOT_W'($urandom_range(7));
    it.coef_value = rand_coef();
    it.own_value = rand_field();
    it.first_upper = rand_field();
    it.first_lower = rand_field();
    it.second_upper = rand_field();
    it.second_lower = rand_field();
    return it;
  endfunction

  task automatic offer_cell(input cell_item_t it, input bit typed, input cell_result_t res);
    int gap;
    bit was_ready;
    if (it.command == CMD_LOAD && it.coef_slot < COEFS_PER_ROW) begin
      was_ready = row_loaded(it.field_kind, it.material);
      coef_seen[it.field_kind][it.material][it.coef_slot] = 1'b1;
      if (!was_ready && row_loaded(it.field_kind, it.material))
        ready_rows.push_back(32'({it.field_kind, it.material}));
    end
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= it.command;
    in_field_kind <= it.field_kind;
    in_component <= it.component;
    in_material <= it.material;
    in_coef_slot <= it.coef_slot;
    in_coef_value <= it.coef_value;
    in_own_value <= it.own_value;
    in_first_upper <= it.first_upper;
    in_first_lower <= it.first_lower;
    in_second_upper <= it.second_upper;
    in_second_lower <= it.second_lower;
    @(posedge clk);
    while (in_stall) begin
      held_cycles++;
      @(posedge clk);
    end
    // transfer taken at this edge
    if (it.command == CMD_LOAD) begin
      loads_done++;
      if (it.coef_slot < COEFS_PER_ROW)
        coef_mem[it.field_kind][it.material][it.coef_slot] = it.coef_value;
    end else begin
      updates_done++;
      if (typed) field_results.push_back(res);
      else field_results.push_back(next_field_value(it));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (field_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int hold, input int n);
    int sent;
    int pick;
    int row;
    cell_item_t it;
    cell_result_t none;
    none = '{default: '0};
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    if (hold > 0) begin
      hold_len = hold;
      hold_req++;
    end
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // a full row for one material, so later updates can use it
        it = rand_item();
        for (int s = 0; s < COEFS_PER_ROW; s++) begin
          offer_cell(coef_load(it.field_kind, it.material, SLOT_W'(s), rand_coef()),
                     1'b0, none);
          sent++;
        end
      end else if (pick < 25 || ready_rows.size() == 0) begin
        it = rand_item();
        it.command = CMD_LOAD;
        if ($urandom_range(9) != 0) it.coef_slot = SLOT_W'($urandom_range(COEFS_PER_ROW - 1));
        offer_cell(it, 1'b0, none);
        sent++;
      end else begin
        it = rand_item();
        row = ready_rows[$urandom_range(ready_rows.size() - 1)];
        it.command = CMD_UPDATE;
        it.field_kind = row[6];
        it.material = row[5:0];
        offer_cell(it, 1'b0, none);
        sent++;
      end
    end
    drain_results();
  endtask

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= hold_len - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      results_seen++;
      if (out_saturated) sat_seen++;
      if (field_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", out_new_value));
      end else begin
        want = field_results.pop_front();
        if (out_new_value !== want.value)
          report_mismatch($sformatf("new_value %h, want %h", out_new_value, want.value));
        if (out_saturated !== want.sat)
          report_mismatch($sformatf("saturated %b, want %b", out_saturated, want.sat));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("fdtd_yee_cell_update regression: fail");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // electric table, material 0: c0 = 1.0, curl slots zero
    add_row(coef_load(KIND_E, 6'd0, SLOT_C0, COEF_ONE), 1'b0, '0, 1'b0);
    add_row(coef_load(KIND_E, 6'd0, SLOT_1, '0), 1'b0, '0, 1'b0);
    add_row(coef_load(KIND_E, 6'd0, SLOT_2, '0), 1'b0, '0, 1'b0);
    add_row(coef_load(KIND_E, 6'd0, SLOT_3, '0), 1'b0, '0, 1'b0);
    add_row(cell_update(KIND_E, COMP_X, 6'd0, VAL_MAX, '0, '0, '0, '0), 1'b1, VAL_MAX, 1'b0);
    add_row(cell_update(KIND_E, COMP_Y, 6'd0, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX),
            1'b1, VAL_MIN, 1'b0);
    // largest curl coefficient against the widest difference clips both ways
    add_row(coef_load(KIND_E, 6'd0, SLOT_2, VAL_MAX), 1'b0, '0, 1'b0);
    add_row(cell_update(KIND_E, COMP_X, 6'd0, '0, VAL_MAX, VAL_MIN, '0, '0),
            1'b1, VAL_MAX, 1'b1);
    add_row(cell_update(KIND_E, COMP_X, 6'd0, '0, VAL_MIN, VAL_MAX, '0, '0),
            1'b1, VAL_MIN, 1'b1);
    // -1 lsb of the sum floors to -1, not 0
    add_row(coef_load(KIND_E, 6'd0, SLOT_3, 32'sd1), 1'b0, '0, 1'b0);
    add_row(cell_update(KIND_E, COMP_X, 6'd0, '0, '0, '0, 32'sd1, '0),
            1'b1, 32'shFFFFFFFF, 1'b0);
    add_row(cell_update(KIND_E, COMP_Z, 6'd0, 32'sh00030000, 32'sd7, -32'sd9, 32'sd5, -32'sd3),
            1'b0, '0, 1'b0);
    add_row(cell_update(KIND_E, COMP_ALT, 6'd0, 32'sh00030000, 32'sd7, -32'sd9, 32'sd5,
                        -32'sd3), 1'b0, '0, 1'b0);
    // magnetic table, top material: c0 = -128.0
    add_row(coef_load(KIND_H, 6'd63, SLOT_C0, VAL_MIN), 1'b0, '0, 1'b0);
    add_row(coef_load(KIND_H, 6'd63, SLOT_1, 32'sh00800000), 1'b0, '0, 1'b0);
    add_row(coef_load(KIND_H, 6'd63, SLOT_2, 32'shFF000000), 1'b0, '0, 1'b0);
    add_row(coef_load(KIND_H, 6'd63, SLOT_3, COEF_ONE), 1'b0, '0, 1'b0);
    add_row(coef_load(KIND_H, 6'd63, SLOT_4, 32'sh12345678), 1'b0, '0, 1'b0);
    add_row(coef_load(KIND_H, 6'd63, SLOT_BAD, 32'shFFFFFFFF), 1'b0, '0, 1'b0);
    add_row(cell_update(KIND_H, COMP_Y, 6'd63, 32'sh00010000, '0, '0, '0, '0),
            1'b1, 32'shFF800000, 1'b0);
    add_row(cell_update(KIND_H, COMP_Y, 6'd63, VAL_MIN, '0, '0, '0, '0), 1'b1, VAL_MAX, 1'b1);
    add_row(cell_update(KIND_H, COMP_X, 6'd63, 32'sh00001234, 32'sh00020000, -32'sh00010000,
                        32'sh00050000, 32'sh00008000), 1'b0, '0, 1'b0);
    add_row(cell_update(KIND_H, COMP_Z, 6'd63, -32'sh00001234, VAL_MAX, '0, VAL_MIN, '0),
            1'b0, '0, 1'b0);

    foreach (dir_rows[i]) offer_cell(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    drain_results();

    run_phase(0, 0, 0, 350);
    run_phase(60, 0, 0, 350);
    run_phase(0, 60, 0, 350);
    run_phase(13, 13, 0, 350);
    // output held off while the sender keeps going: input must back up
    run_phase(0, 0, 300, 350);

    repeat (20) @(posedge clk);
    $display("covered %0d coefficient loads and %0d cell updates over five traffic mixes",
             loads_done, updates_done);
    $display("%0d results checked, %0d clipped, input held off for %0d cycles",
             results_seen, sat_seen, held_cycles);
    if (mismatches == 0) begin
      $display("fdtd_yee_cell_update regression: pass");
    end else begin
      $display("fdtd_yee_cell_update regression: fail");
    end
    $finish;
  end

endmodule
